[rtl/cms_pkg.sv]
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the cluster medoid selector: item and result
// layouts, action and status codes, controller states, pipeline tags.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned ID_FIELD_W    = 16;
  localparam int unsigned COORD_FIELD_W = 10;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SUM_OUT_W     = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_PICK  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [ID_FIELD_W-1:0]    point_id;
    logic [COORD_FIELD_W-1:0] coord_x;
    logic [COORD_FIELD_W-1:0] coord_y;
  } cms_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ID_FIELD_W-1:0] core_id;
    logic                  core_valid;
    logic                  core_completed;
    logic [SUM_OUT_W-1:0]  min_distance_sum;
  } cms_out_t;

  // Flags that travel with one (row, column) pair down the distance pipeline.
  typedef struct packed {
    logic vld;
    logic row_first;
    logic col_first;
    logic col_last;
    logic all_last;
  } cms_tag_t;

endpackage

[rtl/cms_dist_pipe.sv]
// ----------------------------------------------------------------------------
// cms_dist_pipe
// Two-stage squared distance of one point pair: absolute differences, then
// squares summed. The pair tag follows the data.
// ----------------------------------------------------------------------------
module cms_dist_pipe #(
  parameter int unsigned COORD_W = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cms_pkg::cms_tag_t tag_i,
  input  logic [COORD_W-1:0] xa_i,
  input  logic [COORD_W-1:0] ya_i,
  input  logic [COORD_W-1:0] xb_i,
  input  logic [COORD_W-1:0] yb_i,
  output cms_pkg::cms_tag_t tag_o,
  output logic [2*COORD_W:0] sum_o
);
  import cms_pkg::*;

  cms_tag_t           tag_a_q, tag_b_q;
  logic [COORD_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [2*COORD_W-1:0] sqx, sqy;
  logic [2*COORD_W:0] sum_d, sum_q;

  always_comb begin
    dx_d  = (xa_i >= xb_i) ? (xa_i - xb_i) : (xb_i - xa_i);
    dy_d  = (ya_i >= yb_i) ? (ya_i - yb_i) : (yb_i - ya_i);
    sqx   = {{COORD_W{1'b0}}, dx_q} * {{COORD_W{1'b0}}, dx_q};
    sqy   = {{COORD_W{1'b0}}, dy_q} * {{COORD_W{1'b0}}, dy_q};
    sum_d = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sum_q <= sum_d;
  end

  assign tag_o = tag_b_q;
  assign sum_o = sum_q;

endmodule

[rtl/cluster_medoid_select.sv]
// ----------------------------------------------------------------------------
// cluster_medoid_select
// Member store of one cluster with medoid pick: clear, add point, choose the
// member with the smallest summed squared distance to all members as core.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------
//  item in  | start / busy                 | item_i   (cms_in_t)
//  result   | result_valid_o, 1-cycle pulse| result_o (cms_out_t)
//
//  Clear and add: result in the cycle after start; a new item every cycle.
//  Pick of n members: the single distance pipeline walks every member pair
//  through the two read ports of the member memory, then drains and
//  finishes before the result. Empty pick returns in the cycle after start.
//  Reset clears count, controller and core state; the member memory is not cleared.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module cluster_medoid_select #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cms_pkg::cms_in_t  item_i,
  output logic              result_valid_o,
  output cms_pkg::cms_out_t result_o
);
  import cms_pkg::*;

  localparam int unsigned IdW      = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int unsigned CoordW   = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS
                                                                  : COORD_FIELD_W;
  localparam int unsigned AddrW    = $clog2(MAX_POINTS);
  localparam int unsigned CntW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned PairW    = 2 * CoordW + 1;
  localparam int unsigned SumCalcW = PairW + CntW;
  localparam int unsigned SumW     = (SumCalcW > SUM_OUT_W) ? SumCalcW : SUM_OUT_W + 1;
  localparam int unsigned MemW     = IdW + 2 * CoordW;

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_m1;
  logic [AddrW-1:0] i_q, i_d, j_q, j_d, last_q, last_d;
  logic [IdW-1:0]   cur_id_q, cur_id_d, prev_id_q, prev_id_d;
  logic             cur_vld_q, cur_vld_d, prev_vld_q, prev_vld_d;
  logic             compl_q, compl_d;
  logic             res_vld_q, res_vld_d;
  cms_out_t         res_q, res_d;

  logic [MemW-1:0]  mem_q [MAX_POINTS];
  logic [MemW-1:0]  rd_a_q, rd_b_q;
  logic             we;
  logic [IdW-1:0]   id_in;
  logic [MemW-1:0]  wr_word;

  logic             issue_vld;
  cms_tag_t         tag_s0, tag_s1_q, tag_s3;
  logic [PairW-1:0] pair_sum;
  logic [IdW-1:0]   id_s1, id_s2_q, id_s3_q;
  logic [SumW-1:0]  acc_q, row_sum, best_q;
  logic [IdW-1:0]   best_id_q;
  logic             take_best;
  logic [SUM_OUT_W-1:0] report;

  assign id_in   = item_i.point_id[IdW-1:0];
  assign wr_word = {id_in, item_i.coord_x[CoordW-1:0], item_i.coord_y[CoordW-1:0]};
  assign cnt_m1  = cnt_q - CntW'(1);
  assign busy    = (state_q != S_IDLE);

  // Member memory: one write port, two registered read ports.
  // Writes happen only while idle; both read ports read every cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[cnt_q[AddrW-1:0]] <= wr_word;
    end
    rd_a_q <= mem_q[i_q];
    rd_b_q <= mem_q[j_q];
  end

  assign tag_s0 = '{vld:       issue_vld,
                    row_first: (i_q == '0),
                    col_first: (j_q == '0),
                    col_last:  (j_q == last_q),
                    all_last:  (i_q == last_q) && (j_q == last_q)};

  assign id_s1 = rd_a_q[MemW-1 -: IdW];

  cms_dist_pipe #(
    .COORD_W (CoordW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_s1_q),
    .xa_i   (rd_a_q[2*CoordW-1 -: CoordW]),
    .ya_i   (rd_a_q[CoordW-1:0]),
    .xb_i   (rd_b_q[2*CoordW-1 -: CoordW]),
    .yb_i   (rd_b_q[CoordW-1:0]),
    .tag_o  (tag_s3),
    .sum_o  (pair_sum)
  );

  always_comb begin
    row_sum   = (tag_s3.col_first ? '0 : acc_q) + SumW'(pair_sum);
    take_best = tag_s3.vld && tag_s3.col_last && (tag_s3.row_first || (row_sum < best_q));
    report    = (|best_q[SumW-1:SUM_OUT_W]) ? '1 : best_q[SUM_OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    id_s2_q <= id_s1;
    id_s3_q <= id_s2_q;
    if (tag_s3.vld) begin
      acc_q <= row_sum;
    end
    if (take_best) begin
      best_q    <= row_sum;
      best_id_q <= id_s3_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    last_d     = last_q;
    cur_id_d   = cur_id_q;
    cur_vld_d  = cur_vld_q;
    prev_id_d  = prev_id_q;
    prev_vld_d = prev_vld_q;
    compl_d    = compl_q;
    we         = 1'b0;
    issue_vld  = 1'b0;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_vld_d              = 1'b1;
          res_d.status           = STAT_OK;
          res_d.core_id          = ID_FIELD_W'(cur_id_q);
          res_d.core_valid       = cur_vld_q;
          res_d.core_completed   = compl_q;
          res_d.min_distance_sum = '0;
          case (item_i.action)
            ACT_CLEAR: begin
              cnt_d = '0;
            end
            ACT_ADD: begin
              if (cur_vld_q && (id_in == cur_id_q)) begin
                res_d.status = STAT_IGNORED;
              end else if (cnt_q == CntW'(MAX_POINTS)) begin
                res_d.status = STAT_FULL;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            ACT_PICK: begin
              if (cnt_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                res_vld_d = 1'b0;
                state_d   = S_RUN;
                i_d       = '0;
                j_d       = '0;
                last_d    = cnt_m1[AddrW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        issue_vld = 1'b1;
        if (j_q == last_q) begin
          j_d = '0;
          if (i_q == last_q) begin
            state_d = S_DRAIN;
          end else begin
            i_d = i_q + AddrW'(1);
          end
        end else begin
          j_d = j_q + AddrW'(1);
        end
      end
      S_DRAIN: begin
        if (tag_s3.vld && tag_s3.all_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        compl_d    = (cur_vld_q && (best_id_q == cur_id_q)) ||
                     (prev_vld_q && (best_id_q == prev_id_q));
        prev_id_d  = cur_id_q;
        prev_vld_d = cur_vld_q;
        cur_id_d   = best_id_q;
        cur_vld_d  = 1'b1;
        res_vld_d              = 1'b1;
        res_d.status           = STAT_OK;
        res_d.core_id          = ID_FIELD_W'(best_id_q);
        res_d.core_valid       = 1'b1;
        res_d.core_completed   = compl_d;
        res_d.min_distance_sum = report;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      last_q     <= '0;
      cur_id_q   <= '0;
      cur_vld_q  <= 1'b0;
      prev_id_q  <= '0;
      prev_vld_q <= 1'b0;
      compl_q    <= 1'b0;
      res_vld_q  <= 1'b0;
      tag_s1_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      last_q     <= last_d;
      cur_id_q   <= cur_id_d;
      cur_vld_q  <= cur_vld_d;
      prev_id_q  <= prev_id_d;
      prev_vld_q <= prev_vld_d;
      compl_q    <= compl_d;
      res_vld_q  <= res_vld_d;
      tag_s1_q   <= tag_s0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_POINTS))
    else $error("member count beyond store depth");

  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.action == ACT_PICK) && (cnt_q == '0))
    |=> (result_valid_o && (result_o.status == STAT_EMPTY) && !busy))
    else $error("empty pick not reported at once");

  a_pipe_in_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_s3.vld |-> ((state_q == S_RUN) || (state_q == S_DRAIN)))
    else $error("distance pipeline active outside a pick");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> (result_valid_o && !busy && result_o.core_valid))
    else $error("pick finished without a result");

  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RUN) || (state_q == S_DRAIN)) |-> !result_valid_o)
    else $error("result while pick runs");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == STAT_FULL)) |-> (cnt_q == CntW'(MAX_POINTS)))
    else $error("store full reported below depth");
`endif

endmodule
